/* design/dgal_pkg.sv */
// ----------------------------------------------------------------------------
// dgal_pkg - shared constants for the distance gain and air lowpass block
// Register indexes, fixed field widths and the cutoff constant used when the
// gain and the lowpass coefficients are derived.
// ----------------------------------------------------------------------------
package dgal_pkg;

	localparam int DIST_W    = 24;
	localparam int RATE_W    = 18;
	localparam int GAIN_W    = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// pi * 198000 Hz * 256, rounded
	localparam int K_W = 28;
	localparam logic [K_W-1:0] PI_CUTOFF_K = 28'd159241048;

	// Denominator K + rate * distance never reaches 2^43
	localparam int DEN_W = RATE_W + DIST_W + 1;

	// Ten metres in 1/256 m units
	localparam logic [DIST_W-1:0] NEAR_LIMIT = 24'd2560;

	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;

	localparam logic [DIST_W-1:0] DISTANCE_RESET = 24'd256;
	localparam logic [RATE_W-1:0] RATE_RESET     = 18'd44100;

endpackage

/* design/distance_gain_air_lowpass_top.sv */
// ----------------------------------------------------------------------------
// distance_gain_air_lowpass_top - distance cue for one audio channel
// Scales each sample by 1/distance with saturation and, beyond ten metres,
// runs it through a first-order bilinear lowpass with a distance-set cutoff.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, sample_in        | item in
//  out     | out_valid, out_stall, sample_out     | item out
//  cfg     | cfg_we, cfg_index, cfg_data          | write only
//
//  An item runs MUL_X, SCALE and DONE, adding MUL_A, MUL_B and SUM with the
//  filter, and DONE waits out any output stall; all products go through one
//  shared multiplier, one per cycle. A register write re-derives gain and
//  coefficients with a one bit per cycle divider; the same pass runs after reset.
//  in_stall is high while deriving or while an item is in work; a finished
//  item waits in the output register while the next one is taken in.
// ----------------------------------------------------------------------------
module distance_gain_air_lowpass_top
	import dgal_pkg::*;
#(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int COEFF_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int F      = COEFF_FRAC_BITS;
	localparam int COEF_W = F + 1;
	localparam int MA     = (SW + 1 > RATE_W + 1) ? SW + 1 : RATE_W + 1;
	localparam int MB     = (F + 2 > GAIN_W + 1) ? F + 2 : GAIN_W + 1;
	localparam int PROD_W = MA + MB;
	localparam int ACC_W  = PROD_W + 1;
	localparam int NUM_W  = ((K_W + F > DEN_W - 1) ? K_W + F : DEN_W - 1) + 1;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	localparam logic [COEF_W-1:0] ONE  = {1'b1, {F{1'b0}}};
	localparam logic [ACC_W-1:0]  HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (F - 1);

	localparam logic [3:0] ST_D_MUL = 4'd0;
	localparam logic [3:0] ST_DIV_G = 4'd1;
	localparam logic [3:0] ST_A_DEN = 4'd2;
	localparam logic [3:0] ST_A_NUM = 4'd3;
	localparam logic [3:0] ST_DIV_A = 4'd4;
	localparam logic [3:0] ST_IDLE  = 4'd5;
	localparam logic [3:0] ST_MUL_X = 4'd6;
	localparam logic [3:0] ST_SCALE = 4'd7;
	localparam logic [3:0] ST_MUL_A = 4'd8;
	localparam logic [3:0] ST_MUL_B = 4'd9;
	localparam logic [3:0] ST_SUM   = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic [RATE_W-1:0] rate_q;
	logic [SW-1:0]     prev_in_q;
	logic [SW-1:0]     prev_out_q;

	logic [SW-1:0]       x_q;
	logic [SW-1:0]       scaled_q;
	logic [SW-1:0]       res_q;
	logic [SW-1:0]       sample_out_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [COEF_W-1:0]   a_q;
	logic [COEF_W-1:0]   b_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;

	logic              cfg_hit;
	logic              in_accept;
	logic              out_free;
	logic              active;
	logic [DIST_W-1:0] d_eff;

	logic signed [MA-1:0]     mul_a;
	logic signed [MB-1:0]     mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic [DEN_W:0]   trial;
	logic             qbit;
	logic [DEN_W-1:0] rem_next;
	logic [NUM_W-1:0] num_next;
	logic [COEF_W-1:0] a_next;

	logic [SW-1:0] scale_rs;
	logic [SW-1:0] sum_rs;

	function automatic logic [SW-1:0] round_sat(input logic [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-1:0] shifted;
		logic [ACC_W-SW:0]       top;
		biased  = $signed(v + HALF);
		shifted = biased >>> F;
		top     = shifted[ACC_W-1:SW-1];
		if (&top || ~|top) begin
			return shifted[SW-1:0];
		end else if (top[ACC_W-SW]) begin
			return {1'b1, {(SW-1){1'b0}}};
		end else begin
			return {1'b0, {(SW-1){1'b1}}};
		end
	endfunction

	assign cfg_hit   = cfg_we && (cfg_index == REG_DISTANCE || cfg_index == REG_SAMPLE_RATE);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sample_out = $signed(sample_out_q);
	assign active    = distance_q > NEAR_LIMIT;
	assign d_eff     = (distance_q == '0) ? {{(DIST_W-1){1'b0}}, 1'b1} : distance_q;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_D_MUL: begin
				mul_a = $signed({{(MA-RATE_W){1'b0}}, rate_q});
				mul_b = $signed({{(MB-DIST_W){1'b0}}, d_eff});
			end
			ST_MUL_X: begin
				mul_a = $signed({{(MA-SW){x_q[SW-1]}}, x_q});
				mul_b = $signed({{(MB-GAIN_W){1'b0}}, gain_q});
			end
			ST_MUL_A: begin
				mul_a = $signed({{(MA-SW){scaled_q[SW-1]}}, scaled_q}
					+ {{(MA-SW){prev_in_q[SW-1]}}, prev_in_q});
				mul_b = $signed({{(MB-COEF_W){1'b0}}, a_q});
			end
			ST_MUL_B: begin
				mul_a = $signed({{(MA-SW){prev_out_q[SW-1]}}, prev_out_q});
				mul_b = $signed({{(MB-COEF_W){1'b0}}, b_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// restoring divider step, quotient shifts into num_q
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign qbit     = trial >= {1'b0, den_q};
	assign rem_next = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	assign num_next = {num_q[NUM_W-2:0], qbit};
	assign a_next   = num_next[COEF_W-1:0];

	assign scale_rs = round_sat({prod_q[PROD_W-1], prod_q});
	assign sum_rs   = round_sat({acc_q[PROD_W-1], acc_q} + {prod_q[PROD_W-1], prod_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_D_MUL;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			distance_q  <= DISTANCE_RESET;
			rate_q      <= RATE_RESET;
			prev_in_q   <= '0;
			prev_out_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_D_MUL: begin
					cnt_q   <= CNT_W'(NUM_W);
					state_q <= ST_DIV_G;
				end
				ST_DIV_G: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_A_DEN;
					end
				end
				ST_A_DEN: begin
					state_q <= ST_A_NUM;
				end
				ST_A_NUM: begin
					cnt_q   <= CNT_W'(NUM_W);
					state_q <= ST_DIV_A;
				end
				ST_DIV_A: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= active ? ST_MUL_A : ST_DONE;
				end
				ST_MUL_A: begin
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					prev_in_q  <= scaled_q;
					prev_out_q <= sum_rs;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_D_MUL;
				end
			endcase
			// a register write restarts the derivation
			if (cfg_hit) begin
				state_q <= ST_D_MUL;
				if (cfg_index == REG_DISTANCE) begin
					distance_q <= cfg_data[DIST_W-1:0];
				end else begin
					rate_q <= cfg_data[RATE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_D_MUL: begin
				prod_q <= mul_p;
				num_q  <= (NUM_W'(1) << (8 + F)) + NUM_W'(d_eff >> 1);
				den_q  <= DEN_W'(d_eff);
				rem_q  <= '0;
			end
			ST_DIV_G: begin
				num_q <= num_next;
				rem_q <= rem_next;
				if (cnt_q == CNT_W'(1)) begin
					gain_q <= (|num_next[NUM_W-1:GAIN_W]) ? {GAIN_W{1'b1}}
						: num_next[GAIN_W-1:0];
				end
			end
			ST_A_DEN: begin
				den_q <= DEN_W'(PI_CUTOFF_K) + {1'b0, prod_q[DEN_W-2:0]};
			end
			ST_A_NUM: begin
				num_q <= (NUM_W'(PI_CUTOFF_K) << F) + NUM_W'(den_q >> 1);
				rem_q <= '0;
			end
			ST_DIV_A: begin
				num_q <= num_next;
				rem_q <= rem_next;
				if (cnt_q == CNT_W'(1)) begin
					a_q <= a_next;
					b_q <= ONE - a_next;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					x_q <= sample_in;
				end
			end
			ST_MUL_X: begin
				prod_q <= mul_p;
			end
			ST_SCALE: begin
				scaled_q <= scale_rs;
				res_q    <= scale_rs;
			end
			ST_MUL_A: begin
				prod_q <= mul_p;
			end
			ST_MUL_B: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_SUM: begin
				res_q <= sum_rs;
			end
			ST_DONE: begin
				if (out_free) begin
					sample_out_q <= res_q;
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

`ifndef SYNTH
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_G || state_q == ST_DIV_A) |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_coeff_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((a_q + b_q) == ONE))
		else $error("lowpass coefficients do not sum to one");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SUM) |=> ($stable(prev_in_q) && $stable(prev_out_q)))
		else $error("filter state changed outside the filter update");

	a_busy_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DONE && !out_valid_q) |=> !out_valid_q)
		else $error("output raised without a finished item");
`endif

endmodule
